>>> src/tts_pkg.sv
// Shared types and constants for the text terminal with scroll.
// Used by the cell RAM and by the top level; no dependencies.
package tts_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CHAR_W = 7;

    localparam int DEF_TEXT_COLS = 79;
    localparam int DEF_TEXT_ROWS = 59;

    localparam logic [7:0] DEVICE_PORT_RESET = 8'h11;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_TILDE = 7'h7E;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;

    localparam logic [1:0] OP_PORT_WRITE = 2'd0;
    localparam logic [1:0] OP_READ_CELL  = 2'd1;
    localparam logic [1:0] OP_CLEAR      = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_PUT
    } tts_state_t;

    typedef logic [ADDR_W-1:0] tts_addr_t;

    // Cells are laid out row-major with 128 columns per row.
    function automatic tts_addr_t cell_addr(input logic [COL_W-1:0] c,
                                            input logic [ROW_W-1:0] r);
        cell_addr = {r, c};
    endfunction

endpackage

>>> src/tts_cell_ram.sv
// Character cell store: 8192 cells of 7 bits, one write and one read port.
// Read data is registered and appears in the cycle after the read. Depends on tts_pkg.
module tts_cell_ram
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  tts_addr_t         waddr,
    input  logic [CHAR_W-1:0] wdata,
    input  logic              re,
    input  tts_addr_t         raddr,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [2**ADDR_W];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/text_terminal_scroll.sv
// Text terminal with scroll: cursor control and cell store behind a
// valid/stall item interface. Depends on tts_pkg and tts_cell_ram.
//
// After reset, the 8192-cell store is blanked by a clearing pass, during
// which in_stall is high. A port write that does not scroll (or is
// ignored), and an unused op, load their result in the cycle they are
// accepted; a cell read passes through ST_READ because of the store's
// registered read port. A clear-screen item sweeps the whole store one
// cell a cycle. A port write that scrolls copies (TEXT_ROWS-1)*TEXT_COLS
// cells through the single read and single write port, then blanks
// TEXT_COLS cells.
// One item is in work at a time; a finished result stays in the output
// register until it is taken, and the next item is accepted in that same
// cycle at the earliest.
module text_terminal_scroll
    import tts_pkg::*;
#(
    parameter int TEXT_COLS = DEF_TEXT_COLS,
    parameter int TEXT_ROWS = DEF_TEXT_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [7:0]        dev,
    input  logic [7:0]        data,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic [COL_W-1:0]  cursor_col,
    output logic [ROW_W-1:0]  cursor_row,
    output logic              scrolled,
    output logic [CHAR_W-1:0] cell_char
);

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(TEXT_COLS - 1);
    localparam logic [COL_W-1:0] WRAP_COL  = COL_W'(TEXT_COLS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(TEXT_ROWS - 1);
    localparam logic [ROW_W-1:0] LAST_SRC  = ROW_W'(TEXT_ROWS - 2);
    localparam logic [ROW_W:0]   ROWS_WIDE = (ROW_W+1)'(TEXT_ROWS);

    tts_state_t state_reg, state_next;

    logic [7:0]        device_port_reg;
    logic [COL_W-1:0]  cursor_x_reg, cursor_x_next;
    logic [ROW_W-1:0]  cursor_y_reg, cursor_y_next;
    tts_addr_t         addr_reg, addr_next;
    tts_addr_t         wr_addr_reg, wr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              nl_reg, nl_next;

    logic              out_valid_reg;
    logic              accepted_reg, scrolled_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [CHAR_W-1:0] cell_char_reg;

    logic              out_load;
    logic              out_accepted, out_scrolled;
    logic [CHAR_W-1:0] out_cell;

    logic              mem_we, mem_re;
    tts_addr_t         mem_waddr, mem_raddr;
    logic [CHAR_W-1:0] mem_wdata, mem_rdata;

    logic              take;
    logic [CHAR_W-1:0] ch;
    logic              is_nl, printable, hit, wrap, need_scroll;
    logic [ROW_W:0]    y_inc;
    logic [COL_W-1:0]  pos_x;
    logic [ROW_W-1:0]  pos_y;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;

    tts_cell_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign take     = in_valid && !in_stall;

    // Decode of a port write against the current cursor.
    assign ch          = data[CHAR_W-1:0];
    assign is_nl       = (ch == CHAR_CR) || (ch == CHAR_LF);
    assign printable   = (ch >= CHAR_SPACE) && (ch <= CHAR_TILDE);
    assign hit         = (dev == device_port_reg) && (printable || is_nl);
    assign wrap        = is_nl || (cursor_x_reg == WRAP_COL);
    assign y_inc       = {1'b0, cursor_y_reg} + (ROW_W+1)'(1);
    assign need_scroll = wrap && (y_inc == ROWS_WIDE);
    assign pos_x       = wrap ? '0 : cursor_x_reg;
    assign pos_y       = !wrap ? cursor_y_reg :
                         (need_scroll ? LAST_ROW : y_inc[ROW_W-1:0]);

    assign a_col = addr_reg[COL_W-1:0];
    assign a_row = addr_reg[ADDR_W-1:COL_W];

    always_comb
    begin
        state_next    = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        addr_next     = addr_reg;
        wr_addr_next  = wr_addr_reg;
        wr_pend_next  = 1'b0;
        char_next     = char_reg;
        nl_next       = nl_reg;
        out_load      = 1'b0;
        out_accepted  = 1'b0;
        out_scrolled  = 1'b0;
        out_cell      = '0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = CHAR_SPACE;
        mem_re        = 1'b0;
        mem_raddr     = cell_addr(col, row);

        // A copy read in the previous cycle lands here.
        if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = mem_rdata;
        end

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = CHAR_SPACE;
                addr_next = addr_reg + ADDR_W'(1);
                if (&addr_reg)
                begin
                    state_next = ST_IDLE;
                    out_load   = (state_reg == ST_CLEAR);
                end
            end

            ST_IDLE:
            begin
                if (take)
                begin
                    case (op)
                        OP_PORT_WRITE:
                        begin
                            if (hit)
                            begin
                                out_accepted  = 1'b1;
                                cursor_x_next = is_nl ? pos_x : pos_x + COL_W'(1);
                                cursor_y_next = pos_y;
                                char_next     = ch;
                                nl_next       = is_nl;
                                if (need_scroll)
                                begin
                                    addr_next  = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    mem_we    = !is_nl;
                                    mem_waddr = cell_addr(pos_x, pos_y);
                                    mem_wdata = ch;
                                    out_load  = 1'b1;
                                end
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        OP_READ_CELL:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            cursor_x_next = '0;
                            cursor_y_next = '0;
                            addr_next     = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                out_cell   = mem_rdata;
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCROLL:
            begin
                // Read the cell one row below; it is written back next cycle.
                mem_re       = 1'b1;
                mem_raddr    = cell_addr(a_col, a_row + ROW_W'(1));
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                if (a_col == LAST_COL)
                begin
                    addr_next = cell_addr('0, a_row + ROW_W'(1));
                    if (a_row == LAST_SRC)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_BLANK;
            end

            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = CHAR_SPACE;
                addr_next = addr_reg + ADDR_W'(1);
                if (a_col == LAST_COL)
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                mem_we       = !nl_reg;
                mem_waddr    = cell_addr('0, LAST_ROW);
                mem_wdata    = char_reg;
                out_accepted = 1'b1;
                out_scrolled = 1'b1;
                out_load     = 1'b1;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            device_port_reg <= DEVICE_PORT_RESET;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            addr_reg        <= '0;
            wr_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            addr_reg     <= addr_next;
            wr_pend_reg  <= wr_pend_next;
            if (cfg_we)
            begin
                device_port_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        char_reg    <= char_next;
        nl_reg      <= nl_next;
        if (out_load)
        begin
            accepted_reg   <= out_accepted;
            scrolled_reg   <= out_scrolled;
            cell_char_reg  <= out_cell;
            cursor_col_reg <= cursor_x_next;
            cursor_row_reg <= cursor_y_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign scrolled   = scrolled_reg;
    assign cell_char  = cell_char_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;

endmodule

>>> sim/text_terminal_scroll_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_terminal_scroll: it drives port writes, cell reads
// and clears, predicts cursor, scroll and cell contents, and checks each result item.
// Depends on tts_pkg and the text_terminal_scroll RTL.
module text_terminal_scroll_tb;
    import tts_pkg::*;

    localparam int COLS           = DEF_TEXT_COLS;
    localparam int ROWS           = DEF_TEXT_ROWS;
    localparam int CELLS          = 1 << ADDR_W;
    localparam int ITEMS_PER_PASS = 400;
    localparam int WATCHDOG_LIMIT = 50000;

    localparam logic [1:0]        OP_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_DEL  = 7'h7F;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       dev;
        logic [7:0]       data;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wait_drain;
    } term_cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic [CHAR_W-1:0] cell_char;
    } term_status_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [7:0]        cfg_wdata  = '0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [1:0]        op         = '0;
    logic [7:0]        dev        = '0;
    logic [7:0]        data       = '0;
    logic [COL_W-1:0]  col        = '0;
    logic [ROW_W-1:0]  row        = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              accepted;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;

    // Predicted terminal state.
    logic [CHAR_W-1:0] screen_cells [0:CELLS-1];
    logic [COL_W-1:0]  cur_col  = '0;
    logic [ROW_W-1:0]  cur_row  = '0;
    logic [7:0]        port_sel = DEVICE_PORT_RESET;

    term_cmd_t    pending_cmds[$];
    term_status_t predicted_status[$];
    term_cmd_t    held_cmd   = '0;
    bit           drain_next = 1'b0;
    int           burst_left = 0;
    int           gap_left   = 0;
    int           stall_mode = 0;
    int           stall_span = 0;
    int           idle_cycles = 0;
    int           mismatches = 0;

    text_terminal_scroll DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .dev        (dev),
        .data       (data),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .scrolled   (scrolled),
        .cell_char  (cell_char)
    );

    always #10 clk = ~clk;

    task automatic apply_terminal_cmd(input term_cmd_t c, output term_status_t s);
        logic [CHAR_W-1:0] ch;
        logic              newline;
        logic              printable;
        int                rr;
        int                cc;
        ch        = c.data[CHAR_W-1:0];
        newline   = (ch == CHAR_CR) || (ch == CHAR_LF);
        printable = (ch >= CHAR_SPACE) && (ch <= CHAR_TILDE);
        s         = '0;
        case (c.op)
            OP_PORT_WRITE:
            begin
                if (c.dev == port_sel && (printable || newline))
                begin
                    s.accepted = 1'b1;
                    if (newline || cur_col == COLS)
                    begin
                        cur_col = '0;
                        if (cur_row == ROWS - 1)
                        begin
                            // The bottom row is full: move the text area up one row.
                            for (rr = 0; rr < ROWS - 1; rr++)
                                for (cc = 0; cc < COLS; cc++)
                                    screen_cells[{rr[ROW_W-1:0], cc[COL_W-1:0]}] =
                                        screen_cells[{rr[ROW_W-1:0] + 1'b1, cc[COL_W-1:0]}];
                            for (cc = 0; cc < COLS; cc++)
                                screen_cells[{cur_row, cc[COL_W-1:0]}] = CHAR_SPACE;
                            s.scrolled = 1'b1;
                        end
                        else
                        begin
                            cur_row = cur_row + 1'b1;
                        end
                    end
                    if (!newline)
                    begin
                        screen_cells[{cur_row, cur_col}] = ch;
                        cur_col = cur_col + 1'b1;
                    end
                end
            end
            OP_READ_CELL:
            begin
                s.cell_char = screen_cells[{c.row, c.col}];
            end
            OP_CLEAR:
            begin
                for (rr = 0; rr < CELLS; rr++)
                    screen_cells[rr] = CHAR_SPACE;
                cur_col = '0;
                cur_row = '0;
            end
            default:
            begin
            end
        endcase
        s.cursor_col = cur_col;
        s.cursor_row = cur_row;
    endtask

    function automatic void push_cmd(input logic [1:0] o, input logic [7:0] d,
                                     input logic [7:0] b, input logic [COL_W-1:0] c,
                                     input logic [ROW_W-1:0] r);
        term_cmd_t t;
        t.op         = o;
        t.dev        = d;
        t.data       = b;
        t.col        = c;
        t.row        = r;
        t.wait_drain = drain_next || ($urandom_range(0, 199) == 0);
        drain_next   = 1'b0;
        pending_cmds.push_back(t);
    endfunction

    // Off-path items: foreign ports, unprintable bytes, reads and the unused op.
    // Returns how many of them the terminal actually acts on.
    task automatic push_noise(output int counted);
        logic [7:0]        d;
        logic [CHAR_W-1:0] ch;
        int                k;
        counted = 0;
        case ($urandom_range(0, 4))
            0:
            begin
                do
                    d = 8'($urandom_range(0, 255));
                while (d == port_sel);
                push_cmd(OP_PORT_WRITE, d, 8'($urandom_range(0, 255)), COL_W'($urandom),
                         ROW_W'($urandom));
            end
            1:
            begin
                k  = $urandom_range(0, 33);
                ch = (k < 32 && k != CHAR_CR && k != CHAR_LF) ? k[CHAR_W-1:0] : CHAR_DEL;
                push_cmd(OP_PORT_WRITE, port_sel, {1'($urandom_range(0, 1)), ch},
                         COL_W'($urandom), ROW_W'($urandom));
            end
            2:
            begin
                push_cmd(OP_READ_CELL, 8'($urandom), 8'($urandom),
                         COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
                counted = 1;
            end
            3:
            begin
                push_cmd(OP_READ_CELL, 8'($urandom), 8'($urandom),
                         COL_W'($urandom_range(0, COLS)), ROW_W'($urandom_range(0, ROWS - 1)));
                counted = 1;
            end
            default:
            begin
                push_cmd(OP_UNUSED, 8'($urandom), 8'($urandom), COL_W'($urandom),
                         ROW_W'($urandom));
            end
        endcase
    endtask

    // Text is sent as lines of random content ending in CR or LF; a few lines
    // run past the last column so the cursor wraps.
    task automatic load_text_pass(input int target);
        int made;
        int lines;
        int len;
        int k;
        int extra;
        made  = 0;
        lines = 0;
        while (made < target)
        begin
            drain_next = (lines == 3) || ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 59) == 0)
            begin
                push_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), COL_W'($urandom),
                         ROW_W'($urandom));
                made++;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 30);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_noise(extra);
                    made += extra;
                end
                push_cmd(OP_PORT_WRITE, port_sel,
                         {1'($urandom_range(0, 1)), 7'($urandom_range(32, 126))},
                         COL_W'($urandom), ROW_W'($urandom));
                made++;
            end
            push_cmd(OP_PORT_WRITE, port_sel,
                     {1'($urandom_range(0, 1)), ($urandom_range(0, 1) ? CHAR_CR : CHAR_LF)},
                     COL_W'($urandom), ROW_W'($urandom));
            made++;
            lines++;
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || predicted_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_device_port(input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        port_sel   = v;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Sender: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        term_cmd_t    nxt;
        term_status_t st;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            op         <= '0;
            dev        <= '0;
            data       <= '0;
            col        <= '0;
            row        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_terminal_cmd(held_cmd, st);
                predicted_status.push_back(st);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].wait_drain && predicted_status.size() != 0))
                begin
                    nxt       = pending_cmds.pop_front();
                    held_cmd <= nxt;
                    op       <= nxt.op;
                    dev      <= nxt.dev;
                    data     <= nxt.data;
                    col      <= nxt.col;
                    row      <= nxt.row;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern switches between randomly chosen modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_span <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(16, 400);
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_span[2];
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        term_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_status.size() == 0)
            begin
                $error("result item arrived with no prediction waiting");
                mismatches++;
            end
            else
            begin
                want = predicted_status.pop_front();
                check_field("accepted", 8'(want.accepted), 8'(accepted));
                check_field("cursor_col", 8'(want.cursor_col), 8'(cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(cursor_row));
                check_field("scrolled", 8'(want.scrolled), 8'(scrolled));
                check_field("cell_char", 8'(want.cell_char), 8'(cell_char));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] port_plan [0:4];
        int         i;
        for (i = 0; i < CELLS; i++)
            screen_cells[i] = CHAR_SPACE;
        port_plan[0] = 8'h00;
        port_plan[1] = 8'hFF;
        port_plan[2] = 8'($urandom_range(1, 254));
        port_plan[3] = DEVICE_PORT_RESET;
        port_plan[4] = 8'($urandom_range(0, 255));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset port number.
        push_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 6'd0);
        push_cmd(OP_READ_CELL, 8'hFF, 8'hFF, 7'd127, 6'd63);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b0, CHAR_SPACE}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b0, CHAR_TILDE}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b1, CHAR_TILDE}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET - 8'd1, 8'h41, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b0, CHAR_DEL}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, 8'h00, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, 8'h1F, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, 8'hFF, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b0, CHAR_CR}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b0, CHAR_LF}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, {1'b1, CHAR_CR}, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, 8'h5A, 7'd0, 6'd0);
        push_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 6'd0);
        push_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd1, 6'd0);
        push_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 6'd3);
        push_cmd(OP_UNUSED, 8'hFF, 8'hFF, 7'd127, 6'd63);
        push_cmd(OP_CLEAR, 8'h00, 8'h00, 7'd0, 6'd0);
        push_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd1, 6'd0);
        push_cmd(OP_PORT_WRITE, 8'hFF, 8'h41, 7'd0, 6'd0);
        push_cmd(OP_PORT_WRITE, DEVICE_PORT_RESET, 8'h41, 7'd0, 6'd0);
        wait_idle();

        for (i = 0; i < 5; i++)
        begin
            write_device_port(port_plan[i]);
            load_text_pass(ITEMS_PER_PASS);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
